// ===== hdl/dlfb_pkg.sv =====
package dlfb_pkg;

  localparam int ACC_W = 40;   // accumulator width
  localparam int VAL_W = 16;   // Q4.12 operand width
  localparam int RES_W = 32;   // result width
  localparam int CNT_W = 7;    // loop counter, holds up to 127

  // function codes
  localparam logic [2:0] F_LDW = 3'd0;
  localparam logic [2:0] F_LDB = 3'd1;
  localparam logic [2:0] F_FWD = 3'd2;
  localparam logic [2:0] F_CLR = 3'd3;
  localparam logic [2:0] F_BWD = 3'd4;
  localparam logic [2:0] F_RWG = 3'd5;
  localparam logic [2:0] F_RBG = 3'd6;

  // result kinds
  localparam logic [1:0] K_LOGIT = 2'd0;
  localparam logic [1:0] K_IGRAD = 2'd1;
  localparam logic [1:0] K_WGRAD = 2'd2;
  localparam logic [1:0] K_BGRAD = 2'd3;

  typedef struct packed {
    logic [2:0]              func;
    logic [3:0]              token;
    logic [4:0]              row;
    logic [5:0]              col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [3:0]              out_token;
    logic [5:0]              index;
    logic signed [RES_W-1:0] result_value;
    logic                    last_result;
  } out_item_t;

  // control that travels with one multiply-accumulate
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] tag;
  } mac_ctl_t;

  // 40-bit add that clips at the rails
  function automatic logic signed [ACC_W-1:0] sat_add40(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // Q.24 to Q.12, rounding toward minus infinity
  function automatic logic signed [ACC_W-13:0] floor_q12(
    input logic signed [ACC_W-1:0] v
  );
    return $signed(v[ACC_W-1:12]);
  endfunction

  // clip to 32 bits
  function automatic logic signed [RES_W-1:0] sat32(input logic signed [RES_W+8:0] v);
    if (v > 41'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -41'sh0_8000_0000) return 32'sh8000_0000;
    return v[RES_W-1:0];
  endfunction

endpackage

// ===== hdl/dlfb_ram.sv =====
module dlfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dlfb_mac.sv =====
module dlfb_mac import dlfb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                in_ctl,
  input  logic signed [VAL_W-1:0] x,
  input  logic signed [VAL_W-1:0] y,
  input  logic signed [ACC_W-1:0] acc,
  output mac_ctl_t                out_ctl,
  output logic signed [ACC_W-1:0] sum
);

  logic signed [2*VAL_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc_q;

  // product and old accumulator registered together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.tag <= in_ctl.tag;
    prod        <= x * y;
    acc_q       <= acc;
  end

  // saturating accumulate, written back by the caller
  assign sum = sat_add40(acc_q, ACC_W'(prod));

endmodule

// ===== hdl/dense_layer_forward_backward_top.sv =====
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_item  (in_item_t)
// out     | out | out_valid / out_ready| out_item (out_item_t)
//
// Loads and no-ops take effect at accept. A forward element steps over the VOCAB_SIZE
// columns of its weight row, a backward element over the MODEL_DIM rows of its column,
// one a cycle. A last mark then emits every logit or input gradient; a gradient read
// emits one result. Reset and the clear command sweep the weight-gradient memory with
// in_ready low. A stalled output holds the result sequencer in place.
module dense_layer_forward_backward_top import dlfb_pkg::*; #(
  parameter int MODEL_DIM   = 32,
  parameter int VOCAB_SIZE  = 64,
  parameter int TOKEN_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int W_DEPTH = MODEL_DIM * VOCAB_SIZE;
  localparam int S_DEPTH = TOKEN_SLOTS * MODEL_DIM;
  localparam int W_AW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int S_AW = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int V_AW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int D_AW = (MODEL_DIM > 1) ? $clog2(MODEL_DIM) : 1;
  localparam logic [CNT_W-1:0] V_LAST = CNT_W'(VOCAB_SIZE - 1);
  localparam logic [CNT_W-1:0] D_LAST = CNT_W'(MODEL_DIM - 1);
  localparam logic [W_AW-1:0]  W_LAST = W_AW'(W_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOP  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [W_AW-1:0]  clr_cnt;
  logic             rd_ok;
  logic             bg_upd;
  in_item_t         cur;
  logic             cur_row_ok, cur_col_ok, cur_tok_ok;
  logic [VOCAB_SIZE-1:0] logit_v, bg_v;
  logic [MODEL_DIM-1:0]  ig_v;
  mac_ctl_t         rd_ctl;

  logic acc_in, row_ok, col_ok, tok_ok, is_fwd, out_free, out_load;
  logic [CNT_W-1:0] n_last;

  assign in_ready = (state == ST_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign row_ok   = int'(in_item.row) < MODEL_DIM;
  assign col_ok   = int'(in_item.col) < VOCAB_SIZE;
  assign tok_ok   = int'(in_item.token) < TOKEN_SLOTS;
  assign is_fwd   = (cur.func == F_FWD);
  assign n_last   = is_fwd ? V_LAST : D_LAST;
  assign out_free = !out_valid || out_ready;
  assign out_load = rd_ok && out_free && (state == ST_EMIT || state == ST_READ);

  // memory ports
  logic                    w_we, b_we, s_we, l_we, wg_we, bg_we, ig_we;
  logic [W_AW-1:0]         w_waddr, w_raddr, wg_waddr, wg_raddr;
  logic [S_AW-1:0]         s_waddr, s_raddr;
  logic [V_AW-1:0]         b_waddr, b_raddr, l_waddr, l_raddr, bg_waddr, bg_raddr;
  logic [D_AW-1:0]         ig_waddr, ig_raddr;
  logic [VAL_W-1:0]        w_rd, b_rd, s_rd;
  logic [ACC_W-1:0]        l_rd, wg_rd, bg_rd, ig_rd;
  logic signed [ACC_W-1:0] wg_wdata, bg_wdata;

  mac_ctl_t                l0_ctl, l1_ctl, l0_out, l1_out;
  logic signed [VAL_W-1:0] l0_x, l0_y, l1_x, l1_y;
  logic signed [ACC_W-1:0] l0_acc, l1_acc, l0_sum, l1_sum;

  // loads and input save at accept
  assign w_we    = acc_in && in_item.func == F_LDW && row_ok && col_ok;
  assign w_waddr = W_AW'(int'(in_item.row) * VOCAB_SIZE + int'(in_item.col));
  assign w_raddr = is_fwd ? W_AW'(int'(cur.row) * VOCAB_SIZE + int'(cnt))
                          : W_AW'(int'(cnt) * VOCAB_SIZE + int'(cur.col));
  assign b_we    = acc_in && in_item.func == F_LDB && col_ok;
  assign b_waddr = in_item.col[V_AW-1:0];
  assign b_raddr = cnt[V_AW-1:0];
  assign s_we    = acc_in && in_item.func == F_FWD && row_ok && tok_ok;
  assign s_waddr = S_AW'(int'(in_item.token) * MODEL_DIM + int'(in_item.row));
  assign s_raddr = S_AW'(int'(cur.token) * MODEL_DIM + int'(cnt));

  // accumulator write-back from the lanes
  assign l_we     = l0_out.valid && is_fwd;
  assign l_waddr  = l0_out.tag[V_AW-1:0];
  assign l_raddr  = cnt[V_AW-1:0];
  assign wg_we    = (state == ST_CLEAR) || (l0_out.valid && !is_fwd);
  assign wg_waddr = (state == ST_CLEAR) ? clr_cnt
                  : W_AW'(int'(l0_out.tag) * VOCAB_SIZE + int'(cur.col));
  assign wg_wdata = (state == ST_CLEAR) ? '0 : l0_sum;
  assign wg_raddr = (state == ST_READ) ? W_AW'(int'(cur.row) * VOCAB_SIZE + int'(cur.col))
                  : W_AW'(int'(cnt) * VOCAB_SIZE + int'(cur.col));
  assign ig_we    = l1_out.valid;
  assign ig_waddr = l1_out.tag[D_AW-1:0];
  assign ig_raddr = cnt[D_AW-1:0];

  // bias gradient: read at accept, updated in the cycle after
  assign bg_raddr = (state == ST_IDLE) ? in_item.col[V_AW-1:0] : cur.col[V_AW-1:0];
  assign bg_we    = bg_upd;
  assign bg_waddr = cur.col[V_AW-1:0];
  assign bg_wdata = sat_add40(bg_v[cur.col[V_AW-1:0]] ? $signed(bg_rd) : '0,
                              ACC_W'(cur.value));

  dlfb_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weights (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_item.value),
    .raddr(w_raddr), .rdata(w_rd));
  dlfb_ram #(.WIDTH(VAL_W), .DEPTH(VOCAB_SIZE)) u_biases (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(in_item.value),
    .raddr(b_raddr), .rdata(b_rd));
  dlfb_ram #(.WIDTH(VAL_W), .DEPTH(S_DEPTH)) u_saved (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(in_item.value),
    .raddr(s_raddr), .rdata(s_rd));
  dlfb_ram #(.WIDTH(ACC_W), .DEPTH(VOCAB_SIZE)) u_logit (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l0_sum),
    .raddr(l_raddr), .rdata(l_rd));
  dlfb_ram #(.WIDTH(ACC_W), .DEPTH(W_DEPTH)) u_wgrad (
    .clk, .we(wg_we), .waddr(wg_waddr), .wdata(wg_wdata),
    .raddr(wg_raddr), .rdata(wg_rd));
  dlfb_ram #(.WIDTH(ACC_W), .DEPTH(VOCAB_SIZE)) u_bgrad (
    .clk, .we(bg_we), .waddr(bg_waddr), .wdata(bg_wdata),
    .raddr(bg_raddr), .rdata(bg_rd));
  dlfb_ram #(.WIDTH(ACC_W), .DEPTH(MODEL_DIM)) u_igrad (
    .clk, .we(ig_we), .waddr(ig_waddr), .wdata(l1_sum),
    .raddr(ig_raddr), .rdata(ig_rd));

  // lane operands: forward x*W into logits; backward x*g into wgrad, W*g into igrad
  always_comb begin
    l0_ctl.valid = rd_ctl.valid;
    l0_ctl.tag   = rd_ctl.tag;
    l1_ctl.valid = rd_ctl.valid && !is_fwd;
    l1_ctl.tag   = rd_ctl.tag;
    if (is_fwd) begin
      l0_x   = cur.value;
      l0_y   = $signed(w_rd);
      l0_acc = logit_v[rd_ctl.tag[V_AW-1:0]] ? $signed(l_rd) : '0;
    end else begin
      l0_x   = cur_tok_ok ? $signed(s_rd) : '0;
      l0_y   = cur.value;
      l0_acc = $signed(wg_rd);
    end
    l1_x   = $signed(w_rd);
    l1_y   = cur.value;
    l1_acc = ig_v[rd_ctl.tag[D_AW-1:0]] ? $signed(ig_rd) : '0;
  end

  dlfb_mac u_lane0 (.clk, .rst, .in_ctl(l0_ctl), .x(l0_x), .y(l0_y), .acc(l0_acc),
                    .out_ctl(l0_out), .sum(l0_sum));
  dlfb_mac u_lane1 (.clk, .rst, .in_ctl(l1_ctl), .x(l1_x), .y(l1_y), .acc(l1_acc),
                    .out_ctl(l1_out), .sum(l1_sum));

  // result value for the entry at the read port
  out_item_t               res;
  logic signed [ACC_W-1:0] l_acc, ig_acc, bg_acc;
  logic signed [RES_W+8:0] logit_s;
  always_comb begin
    l_acc   = logit_v[cnt[V_AW-1:0]] ? $signed(l_rd) : '0;
    ig_acc  = ig_v[cnt[D_AW-1:0]] ? $signed(ig_rd) : '0;
    bg_acc  = bg_v[cur.col[V_AW-1:0]] ? $signed(bg_rd) : '0;
    logit_s = (RES_W+9)'($signed(b_rd)) + (RES_W+9)'(floor_q12(l_acc));
    res.out_token   = cur.token;
    res.index       = cnt[5:0];
    res.last_result = (cnt == n_last);
    if (state == ST_READ) begin
      res.out_token   = '0;
      res.index       = cur.col;
      res.last_result = 1'b1;
      if (cur.func == F_RWG) begin
        res.kind         = K_WGRAD;
        res.result_value = (cur_row_ok && cur_col_ok)
                         ? sat32((RES_W+9)'(floor_q12($signed(wg_rd)))) : '0;
      end else begin
        res.kind         = K_BGRAD;
        res.result_value = cur_col_ok ? sat32((RES_W+9)'(bg_acc)) : '0;
      end
    end else if (is_fwd) begin
      res.kind         = K_LOGIT;
      res.result_value = sat32(logit_s);
    end else begin
      res.kind         = K_IGRAD;
      res.result_value = sat32((RES_W+9)'(floor_q12(ig_acc)));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= res;
    end
  end

  // read issue tag, registered in front of the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl.valid <= 1'b0;
    end else begin
      rd_ctl.valid <= (state == ST_LOOP);
    end
    rd_ctl.tag <= cnt;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
      rd_ok   <= 1'b0;
      bg_upd  <= 1'b0;
      logit_v <= '0;
      bg_v    <= '0;
      ig_v    <= '0;
    end else begin
      bg_upd <= 1'b0;
      if (bg_upd) bg_v[cur.col[V_AW-1:0]] <= 1'b1;
      if (l_we) logit_v[l0_out.tag[V_AW-1:0]] <= 1'b1;
      if (ig_we) ig_v[l1_out.tag[D_AW-1:0]] <= 1'b1;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == W_LAST) state <= ST_IDLE;
        end
        ST_IDLE: begin
          cnt   <= '0;
          rd_ok <= 1'b0;
          if (acc_in) begin
            unique case (in_item.func)
              F_FWD: begin
                if (row_ok) state <= ST_LOOP;
                else if (in_item.last) state <= ST_EMIT;
              end
              F_BWD: begin
                if (col_ok) begin
                  state  <= ST_LOOP;
                  bg_upd <= 1'b1;
                end else if (in_item.last) begin
                  state <= ST_EMIT;
                end
              end
              F_CLR: begin
                state   <= ST_CLEAR;
                clr_cnt <= '0;
                bg_v    <= '0;
                ig_v    <= '0;
              end
              F_RWG, F_RBG: state <= ST_READ;
              default: ;
            endcase
          end
        end
        ST_LOOP: begin
          cnt <= cnt + 1'b1;
          if (cnt == n_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          cnt   <= '0;
          rd_ok <= 1'b0;
          if (!rd_ctl.valid && !l0_out.valid) begin
            state <= cur.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (is_fwd) logit_v[cnt[V_AW-1:0]] <= 1'b0;
            else ig_v[cnt[D_AW-1:0]] <= 1'b0;
            cnt   <= cnt + 1'b1;
            rd_ok <= 1'b0;
            if (cnt == n_last) state <= ST_IDLE;
          end else begin
            rd_ok <= 1'b1;
          end
        end
        ST_READ: begin
          if (out_load) state <= ST_IDLE;
          else rd_ok <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item latched at accept
  always_ff @(posedge clk) begin
    if (acc_in) begin
      cur        <= in_item;
      cur_row_ok <= row_ok;
      cur_col_ok <= col_ok;
      cur_tok_ok <= tok_ok;
    end
  end

  // lanes write back only while an element is in flight
  a_lane_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !l0_out.valid && !l1_out.valid)
    else $error("lane write-back outside an element");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || out_ready)
    else $error("result overwrote a pending item");

  // backward element with a valid column updates its bias gradient next cycle
  a_bg_upd: assert property (@(posedge clk) disable iff (rst)
    acc_in && in_item.func == F_BWD && col_ok |=> bg_upd && state == ST_LOOP)
    else $error("bias gradient update missed");

  // no item is taken during the gradient sweep
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready && !rd_ctl.valid)
    else $error("activity during gradient sweep");

endmodule
